### src/assert_macros.svh
// Assertion macros used by the RTL of the quadrature position counter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked at every clock edge outside reset.
`define QHS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every clock edge, reset included.
`define QHS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define QHS_ASSERT(lbl, clk, rst_n, prop, msg)
`define QHS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### src/qhs_pkg.sv
// Types, codes and the half-step decode table of the quadrature position counter.
`default_nettype none
package qhs_pkg;

  // Default width of a position value
  localparam int POSITION_BITS_DEF = 16;

  // Configuration register indexes
  localparam logic [1:0] REG_LOWER_BOUND = 2'd0;
  localparam logic [1:0] REG_UPPER_BOUND = 2'd1;
  localparam logic [1:0] REG_WRAP_MODE   = 2'd2;

  // Input kinds
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_LOAD   = 1'b1;

  // Applied step direction codes
  localparam logic [1:0] DIR_IDLE = 2'd0;
  localparam logic [1:0] DIR_CW   = 2'd1;
  localparam logic [1:0] DIR_CCW  = 2'd2;

  // Emit codes in bits [5:4] of a table entry
  localparam logic [1:0] EMIT_NONE = 2'b00;
  localparam logic [1:0] EMIT_CW   = 2'b01;
  localparam logic [1:0] EMIT_CCW  = 2'b10;

  // Decoder start state
  localparam logic [2:0] DEC_START = 3'd0;

  // Half-step table: row = decoder state, column = {pin_a, pin_b}.
  // Entry = {emit[1:0], 1'b0, next_state[2:0]}; rows 6 and 7 act as start.
  localparam logic [5:0] HALF_STEP_ROWS [8][4] = '{
    '{6'h03, 6'h02, 6'h01, 6'h00},
    '{6'h23, 6'h00, 6'h01, 6'h00},
    '{6'h13, 6'h02, 6'h00, 6'h00},
    '{6'h03, 6'h05, 6'h04, 6'h00},
    '{6'h03, 6'h03, 6'h04, 6'h10},
    '{6'h03, 6'h05, 6'h03, 6'h20},
    '{6'h03, 6'h02, 6'h01, 6'h00},
    '{6'h03, 6'h02, 6'h01, 6'h00}
  };

  // Step request passed from the decoder to the position unit
  typedef struct packed {
    logic valid;  // a step is applied
    logic cw;     // 1 clockwise, 0 counter-clockwise
  } qhs_step_t;

endpackage
`default_nettype wire

### src/quadrature_half_step_position_counter.sv
// Latency: a result beat appears in the output register in the cycle after its input beat is accepted.
// Throughput: one beat per cycle while no result is held; the table step and the
//   bounded add are combinational between the input port and the output register.
// in_tready drops only while a result is held by a low out_tready.
// Reset (rst_n low, synchronous): decoder at start state, step parity 0,
//   position 0, bounds at full range, saturating mode, output empty.
`default_nettype none
`include "assert_macros.svh"
module quadrature_half_step_position_counter #(
  parameter int POSITION_BITS = qhs_pkg::POSITION_BITS_DEF,
  localparam int IN_W  = ((POSITION_BITS + 3 + 7) / 8) * 8,
  localparam int OUT_W = ((POSITION_BITS + 3 + 7) / 8) * 8
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // configuration write port
  input  wire logic                     cfg_wr_en,
  input  wire logic [1:0]               cfg_addr,
  input  wire logic [POSITION_BITS-1:0] cfg_wr_data,
  // input stream
  input  wire logic                     in_tvalid,
  output logic                          in_tready,
  input  wire logic [IN_W-1:0]          in_tdata,  // pin_a, pin_b, new_position, notify
  input  wire logic                     in_tuser,  // command
  // result stream
  output logic                          out_tvalid,
  input  wire logic                     out_tready,
  output logic [OUT_W-1:0]              out_tdata  // position, changed, direction
);

  localparam int P = POSITION_BITS;

  // configuration registers
  logic signed [P-1:0] lower_bound_r, upper_bound_r;
  logic                wrap_mode_r;

  // block state
  logic [2:0]          dec_state_r, dec_state_nxt;
  logic                parity_r, parity_nxt;
  logic signed [P-1:0] pos_r, pos_nxt;

  // output register
  logic                out_valid_r;
  logic signed [P-1:0] out_pos_r;
  logic                out_changed_r;
  logic [1:0]          out_dir_r;
  logic                out_changed_nxt;
  logic [1:0]          out_dir_nxt;

  // input beat fields
  logic                in_fire, in_load;
  logic                in_pin_a, in_pin_b, in_notify;
  logic signed [P-1:0] in_new_pos;
  qhs_pkg::qhs_step_t  step;

  assign in_pin_a   = in_tdata[0];
  assign in_pin_b   = in_tdata[1];
  assign in_new_pos = in_tdata[P+1:2];
  assign in_notify  = in_tdata[P+2];
  assign in_load    = (in_tuser == qhs_pkg::CMD_LOAD);

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  // table step and step filter
  qhs_decoder u_decoder (
    .sample     (!in_load),
    .state      (dec_state_r),
    .parity     (parity_r),
    .pin_a      (in_pin_a),
    .pin_b      (in_pin_b),
    .state_nxt  (dec_state_nxt),
    .parity_nxt (parity_nxt),
    .step       (step)
  );

  // bounded position update
  qhs_position #(
    .POSITION_BITS (P)
  ) u_position (
    .pos          (pos_r),
    .lower_bound  (lower_bound_r),
    .upper_bound  (upper_bound_r),
    .wrap_mode    (wrap_mode_r),
    .load         (in_load),
    .new_position (in_new_pos),
    .step         (step),
    .pos_nxt      (pos_nxt)
  );

  // result flags
  always_comb begin
    if (in_load) begin
      out_changed_nxt = in_notify;
      out_dir_nxt     = qhs_pkg::DIR_IDLE;
    end else begin
      out_changed_nxt = step.valid;
      if (!step.valid) begin
        out_dir_nxt = qhs_pkg::DIR_IDLE;
      end else if (step.cw) begin
        out_dir_nxt = qhs_pkg::DIR_CW;
      end else begin
        out_dir_nxt = qhs_pkg::DIR_CCW;
      end
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_bound_r <= {1'b1, {(P-1){1'b0}}};
      upper_bound_r <= {1'b0, {(P-1){1'b1}}};
      wrap_mode_r   <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        qhs_pkg::REG_LOWER_BOUND: lower_bound_r <= cfg_wr_data;
        qhs_pkg::REG_UPPER_BOUND: upper_bound_r <= cfg_wr_data;
        qhs_pkg::REG_WRAP_MODE:   wrap_mode_r   <= cfg_wr_data[0];
        default: ;
      endcase
    end
  end

  // decoder and position state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_state_r <= qhs_pkg::DEC_START;
      parity_r    <= 1'b0;
      pos_r       <= '0;
    end else if (in_fire) begin
      dec_state_r <= dec_state_nxt;
      parity_r    <= parity_nxt;
      pos_r       <= pos_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_pos_r     <= pos_nxt;
      out_changed_r <= out_changed_nxt;
      out_dir_r     <= out_dir_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_W-P-3){1'b0}}, out_dir_r, out_changed_r, out_pos_r};

  // checks
  logic out_stepped, step_fire, sample_fire;
  assign out_stepped = out_valid_r && (out_dir_r != qhs_pkg::DIR_IDLE);
  assign step_fire   = in_fire && !in_load && step.valid;
  assign sample_fire = in_fire && !in_load;

  `QHS_ASSERT(a_dec_state_reachable, clk, rst_n, dec_state_r < 3'd6, "decoder in unused state")
  `QHS_ASSERT(a_dir_implies_changed, clk, rst_n, out_stepped |-> out_changed_r, "step unflagged")
  `QHS_ASSERT(a_step_clears_parity, clk, rst_n, step_fire |=> !parity_r, "parity kept after step")
  `QHS_ASSERT(a_parity_on_sample, clk, rst_n, !sample_fire |=> $stable(parity_r), "stray parity")

endmodule
`default_nettype wire

### src/qhs_decoder.sv
// Half-step table lookup and the divide-by-two step filter.
`default_nettype none
module qhs_decoder (
  input  wire logic           sample,      // beat is a pin sample
  input  wire logic [2:0]     state,
  input  wire logic           parity,
  input  wire logic           pin_a,
  input  wire logic           pin_b,
  output logic [2:0]          state_nxt,
  output logic                parity_nxt,
  output qhs_pkg::qhs_step_t  step
);

  logic [5:0] entry;
  logic [1:0] emit;
  logic       emitted;

  // Table step
  always_comb begin
    entry   = qhs_pkg::HALF_STEP_ROWS[state][{pin_a, pin_b}];
    emit    = entry[5:4];
    emitted = (emit == qhs_pkg::EMIT_CW) || (emit == qhs_pkg::EMIT_CCW);
  end

  // Only every second emitted code becomes a step
  always_comb begin
    state_nxt  = state;
    parity_nxt = parity;
    step.valid = 1'b0;
    step.cw    = (emit == qhs_pkg::EMIT_CW);
    if (sample) begin
      state_nxt = entry[2:0];
      if (emitted) begin
        parity_nxt = ~parity;
        step.valid = parity;
      end
    end
  end

endmodule
`default_nettype wire

### src/qhs_position.sv
// Bounded position update: step with wrap or saturation, and clamped load.
`default_nettype none
module qhs_position #(
  parameter int POSITION_BITS = qhs_pkg::POSITION_BITS_DEF
) (
  input  wire logic signed [POSITION_BITS-1:0] pos,
  input  wire logic signed [POSITION_BITS-1:0] lower_bound,
  input  wire logic signed [POSITION_BITS-1:0] upper_bound,
  input  wire logic                            wrap_mode,
  input  wire logic                            load,
  input  wire logic signed [POSITION_BITS-1:0] new_position,
  input  wire qhs_pkg::qhs_step_t              step,
  output logic signed [POSITION_BITS-1:0]      pos_nxt
);

  localparam int XW = POSITION_BITS + 1;
  localparam logic signed [XW-1:0] ONE_X = XW'(1);

  logic signed [XW-1:0] pos_x, low_x, hi_x, load_x, step_x, cand_x, res_x;

  always_comb begin
    pos_x  = {pos[POSITION_BITS-1], pos};
    low_x  = {lower_bound[POSITION_BITS-1], lower_bound};
    // effective upper bound never sits below the lower one
    hi_x   = (upper_bound > lower_bound) ? {upper_bound[POSITION_BITS-1], upper_bound}
                                         : low_x;
    load_x = {new_position[POSITION_BITS-1], new_position};
    step_x = step.cw ? (pos_x + ONE_X) : (pos_x - ONE_X);

    // value to bound: loaded position or stepped one
    cand_x = load ? load_x : step_x;

    // wrap to the opposite bound, or clamp
    if (!load && wrap_mode) begin
      if (cand_x > hi_x) begin
        res_x = low_x;
      end else if (cand_x < low_x) begin
        res_x = hi_x;
      end else begin
        res_x = cand_x;
      end
    end else begin
      if (cand_x < low_x) begin
        res_x = low_x;
      end else if (cand_x > hi_x) begin
        res_x = hi_x;
      end else begin
        res_x = cand_x;
      end
    end

    pos_nxt = (load || step.valid) ? res_x[POSITION_BITS-1:0] : pos;
  end

endmodule
`default_nettype wire
